// ===== hdl/gmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Gearbox motor drive package
// Shared field widths, command codes, register indexes and duty constants.
// ----------------------------------------------------------------------------
package gmd_pkg;

  // Field widths of the request and result channels.
  localparam int KIND_W    = 4;
  localparam int GEAR_W    = 6;
  localparam int DUTY_W    = 8;
  localparam int COUNT_W   = 5;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Default module parameters.
  localparam int MAX_GEARS_DEFAULT         = 16;
  localparam int PULSE_COUNT_WIDTH_DEFAULT = 16;

  // Command codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_UP       = 4'd0,
    KIND_DOWN     = 4'd1,
    KIND_SHIFT_TO = 4'd2,
    KIND_NEUTRAL  = 4'd3,
    KIND_REVERSE  = 4'd4,
    KIND_THROTTLE = 4'd5,
    KIND_STOP     = 4'd6,
    KIND_BRAKE    = 4'd7,
    KIND_TICK     = 4'd8
  } kind_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TICKS = 2'd2;

  // Configuration reset values.
  localparam logic               SEQ_MODE_RESET    = 1'b1;
  localparam logic [COUNT_W-1:0] GEAR_COUNT_RESET  = 5'd5;
  localparam logic [TICKS_W-1:0] BRAKE_TICKS_RESET = 16'd100;

  // Duty levels on the enable line.
  localparam logic [DUTY_W-1:0] SHORT_DUTY = 8'd190;
  localparam logic [DUTY_W-1:0] LONG_DUTY  = 8'd255;
  localparam logic [DUTY_W-1:0] FULL_DUTY  = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_STEP  = 8'd10;

endpackage

// ===== hdl/gmd_duty.sv =====
// ----------------------------------------------------------------------------
// Gearbox motor drive gear duty
// Maps a gear position and the usable gear count to the throttle duty.
// ----------------------------------------------------------------------------
module gmd_duty #(
  parameter int MAX_GEARS = gmd_pkg::MAX_GEARS_DEFAULT
) (
  input  logic [$clog2(MAX_GEARS+2)-1:0] pos,
  input  logic [$clog2(MAX_GEARS+2)-1:0] cnt,
  output logic [gmd_pkg::DUTY_W-1:0]     duty
);
  import gmd_pkg::*;

  localparam int POS_W = $clog2(MAX_GEARS + 2);

  localparam logic [POS_W-1:0] POS_REVERSE = '0;
  localparam logic [POS_W-1:0] POS_NEUTRAL = POS_W'(1);

  logic [POS_W-1:0] gear_num;
  logic [POS_W-1:0] half;
  logic [POS_W-1:0] diff;

  // Short gears ramp up to 190, long gears ramp up to 255; gears beyond the
  // count (after the count was lowered) saturate at full duty.
  always_comb begin
    gear_num = pos - POS_W'(1);
    half     = cnt >> 1;
    diff     = '0;
    duty     = '0;
    if (pos == POS_REVERSE) begin
      duty = SHORT_DUTY;
    end else if (pos == POS_NEUTRAL) begin
      duty = '0;
    end else if (gear_num <= half) begin
      diff = half - gear_num;
      duty = SHORT_DUTY - DUTY_W'(diff) * DUTY_STEP;
    end else if (gear_num <= cnt) begin
      diff = cnt - gear_num;
      duty = LONG_DUTY - DUTY_W'(diff) * DUTY_STEP;
    end else begin
      duty = LONG_DUTY;
    end
  end

endmodule

// ===== hdl/gearbox_motor_drive.sv =====
// ----------------------------------------------------------------------------
// Gearbox motor drive
// Keeps the gear position and drives a motor H-bridge: one request in, one
// result out (shown gear, enable duty, both direction lines). Requests are
// taken into an input register and processed, one per clock while the
// result register is free, in a single state-update stage that writes the
// result register, so it sustains one request per cycle unless out_ready
// stalls. The input register and the result register decouple the two
// channels, so a new request is taken while a result still waits. The brake
// pulse is a tick counter that tick requests count down.
// ----------------------------------------------------------------------------
module gearbox_motor_drive #(
  parameter int MAX_GEARS         = gmd_pkg::MAX_GEARS_DEFAULT,
  parameter int PULSE_COUNT_WIDTH = gmd_pkg::PULSE_COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gmd_pkg::TICKS_W-1:0]         cfg_data,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gmd_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [gmd_pkg::GEAR_W-1:0]   in_target_gear,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gmd_pkg::GEAR_W-1:0]   out_shown_gear,
  output logic [gmd_pkg::DUTY_W-1:0]          out_enable_duty,
  output logic                                out_drive_forward,
  output logic                                out_drive_backward
);
  import gmd_pkg::*;

  localparam int POS_W = $clog2(MAX_GEARS + 2);
  localparam int PCW   = PULSE_COUNT_WIDTH;

  localparam logic [POS_W-1:0] POS_REVERSE = '0;
  localparam logic [POS_W-1:0] POS_NEUTRAL = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(MAX_GEARS + 1);
  localparam logic [PCW-1:0]   REM_ONE     = PCW'(1);
  localparam logic [32:0]      PULSE_MAX   = (33'd1 << PCW) - 33'd1;

  // Configuration registers.
  logic               seq_mode_r;
  logic [COUNT_W-1:0] gear_count_r;
  logic [TICKS_W-1:0] brake_ticks_r;

  // Input register.
  logic                     s1_valid_r;
  logic [KIND_W-1:0]        s1_kind_r;
  logic signed [GEAR_W-1:0] s1_target_r;
  logic                     s1_take;

  // Drive state.
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accel_r, accel_nxt;
  logic             full_r, full_nxt;
  logic             fwd_r, fwd_nxt;
  logic             bwd_r, bwd_nxt;
  logic [PCW-1:0]   rem_r, rem_nxt;

  // Result register.
  logic                     out_valid_r;
  logic signed [GEAR_W-1:0] out_gear_r;
  logic [DUTY_W-1:0]        out_duty_r;
  logic                     out_fwd_r;
  logic                     out_bwd_r;

  logic [POS_W-1:0]         cnt;
  logic [PCW-1:0]           brake_load;
  logic                     target_ok;
  logic [GEAR_W-1:0]        cnt_ext;
  logic [DUTY_W-1:0]        gear_duty;
  logic [DUTY_W-1:0]        duty_nxt;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_mode_r    <= SEQ_MODE_RESET;
      gear_count_r  <= GEAR_COUNT_RESET;
      brake_ticks_r <= BRAKE_TICKS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SEQ_MODE:    seq_mode_r    <= cfg_data[0];
        CFG_GEAR_COUNT:  gear_count_r  <= cfg_data[COUNT_W-1:0];
        CFG_BRAKE_TICKS: brake_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the state stage moves whenever the result register is free.
  assign s1_take  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r   <= in_kind;
      s1_target_r <= in_target_gear;
    end
  end

  // Usable gear count and brake pulse length, both clipped to the hardware.
  always_comb begin
    if (gear_count_r > COUNT_W'(MAX_GEARS)) begin
      cnt = POS_W'(MAX_GEARS);
    end else begin
      cnt = POS_W'(gear_count_r);
    end
    if ({17'd0, brake_ticks_r} > PULSE_MAX) begin
      brake_load = PCW'(PULSE_MAX);
    end else begin
      brake_load = PCW'(brake_ticks_r);
    end
    cnt_ext   = {{(GEAR_W-POS_W){1'b0}}, cnt};
    target_ok = !seq_mode_r && (s1_target_r >= -6'sd1) &&
                (s1_target_r <= $signed(cnt_ext));
  end

  // Command decode and next drive state.
  always_comb begin
    pos_nxt   = pos_r;
    accel_nxt = accel_r;
    full_nxt  = full_r;
    fwd_nxt   = fwd_r;
    bwd_nxt   = bwd_r;
    rem_nxt   = rem_r;
    unique case (kind_t'(s1_kind_r))
      KIND_UP: begin
        if (pos_r < cnt + POS_W'(1)) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      KIND_DOWN: begin
        if (pos_r != POS_REVERSE) begin
          pos_nxt = pos_r - POS_W'(1);
        end
      end
      KIND_SHIFT_TO: begin
        if (target_ok) begin
          pos_nxt = POS_W'(s1_target_r + 6'sd1);
        end
      end
      KIND_NEUTRAL: pos_nxt = POS_NEUTRAL;
      KIND_REVERSE: pos_nxt = POS_REVERSE;
      KIND_THROTTLE: begin
        accel_nxt = 1'b1;
        full_nxt  = 1'b0;
        rem_nxt   = '0;
        fwd_nxt   = (pos_r != POS_REVERSE);
        bwd_nxt   = (pos_r == POS_REVERSE);
      end
      KIND_STOP: begin
        accel_nxt = 1'b0;
        full_nxt  = 1'b0;
        if (rem_r != '0) begin
          rem_nxt = '0;
          fwd_nxt = 1'b0;
          bwd_nxt = 1'b0;
        end
      end
      KIND_BRAKE: begin
        accel_nxt = 1'b0;
        full_nxt  = 1'b1;
        rem_nxt   = brake_load;
        fwd_nxt   = (brake_load != '0) && (pos_r == POS_REVERSE);
        bwd_nxt   = (brake_load != '0) && (pos_r != POS_REVERSE);
      end
      KIND_TICK: begin
        if (rem_r != '0) begin
          rem_nxt = rem_r - REM_ONE;
          if (rem_r == REM_ONE) begin
            fwd_nxt = 1'b0;
            bwd_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Throttle duty follows the gear after the request.
  gmd_duty #(
    .MAX_GEARS(MAX_GEARS)
  ) u_duty (
    .pos  (pos_nxt),
    .cnt  (cnt),
    .duty (gear_duty)
  );

  always_comb begin
    if (accel_nxt) begin
      duty_nxt = gear_duty;
    end else if (full_nxt) begin
      duty_nxt = FULL_DUTY;
    end else begin
      duty_nxt = '0;
    end
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_NEUTRAL;
      accel_r     <= 1'b0;
      full_r      <= 1'b0;
      fwd_r       <= 1'b0;
      bwd_r       <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        pos_r   <= pos_nxt;
        accel_r <= accel_nxt;
        full_r  <= full_nxt;
        fwd_r   <= fwd_nxt;
        bwd_r   <= bwd_nxt;
        rem_r   <= rem_nxt;
      end
      if (s1_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_gear_r <= $signed({{(GEAR_W-POS_W){1'b0}}, pos_nxt} - GEAR_W'(1));
      out_duty_r <= duty_nxt;
      out_fwd_r  <= fwd_nxt;
      out_bwd_r  <= bwd_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_shown_gear     = out_gear_r;
  assign out_enable_duty    = out_duty_r;
  assign out_drive_forward  = out_fwd_r;
  assign out_drive_backward = out_bwd_r;

  // A running brake pulse always drives exactly one direction line.
  assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r != '0) |-> (fwd_r != bwd_r))
    else $error("brake pulse active without exactly one direction line");

  // Throttle and full enable never hold together.
  assert property (@(posedge clk) disable iff (!rst_n)
    accel_r |-> !full_r)
    else $error("accelerating and enable_full both set");

  // The gear position never passes the top gear.
  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("gear position out of range");

  // A held request stays in the input register until processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_take) |=> s1_valid_r)
    else $error("pending request lost from input register");

endmodule
